// File: rtl/pci_pkg.sv
// shared types and constants of the processor channel interface
package pci_pkg;

  // default inbound mailbox depth
  localparam int unsigned InboxDepth = 4;

  // access kinds
  typedef enum logic [2:0] {
    ActChWrite      = 3'd0,
    ActChRead       = 3'd1,
    ActChCount      = 3'd2,
    ActHostInWrite  = 3'd3,
    ActHostOutRead  = 3'd4,
    ActHostIntrRead = 3'd5
  } pci_action_e;

  // channel numbers
  localparam logic [6:0] ChLocalAddr  = 7'd16;
  localparam logic [6:0] ChEffHigh    = 7'd17;
  localparam logic [6:0] ChEffLow     = 7'd18;
  localparam logic [6:0] ChSize       = 7'd19;
  localparam logic [6:0] ChTag        = 7'd20;
  localparam logic [6:0] ChCommand    = 7'd21;
  localparam logic [6:0] ChTagMask    = 7'd22;
  localparam logic [6:0] ChTagUpdate  = 7'd23;
  localparam logic [6:0] ChTagStatus  = 7'd24;
  localparam logic [6:0] ChEventAck   = 7'd27;
  localparam logic [6:0] ChOutMbox    = 7'd28;
  localparam logic [6:0] ChInMbox     = 7'd29;
  localparam logic [6:0] ChIntrMbox   = 7'd30;
  localparam logic [6:0] ChRandom     = 7'd74;

  // dma command words
  localparam logic [31:0] CmdGet = 32'h0000_0040;
  localparam logic [31:0] CmdPut = 32'h0000_0020;

  // one input word
  typedef struct packed {
    logic [2:0]  action;
    logic [6:0]  channel;
    logic [31:0] write_data;
    logic [31:0] random_word;
  } pci_item_t;

  // one result word
  typedef struct packed {
    logic [31:0] read_data;
    logic        broadcast;
    logic        dma_valid;
    logic        dma_put;
    logic [31:0] dma_local_addr;
    logic [31:0] dma_eff_high;
    logic [31:0] dma_eff_low;
    logic [31:0] dma_size;
    logic [31:0] dma_tag;
    logic        refused;
  } pci_result_t;

endpackage

// File: rtl/pci_in_if.sv
// input channel of the processor channel interface
interface pci_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [6:0]  channel;
  logic [31:0] write_data;
  logic [31:0] random_word;

  modport source (output valid, action, channel, write_data, random_word, input ready);
  modport sink   (input valid, action, channel, write_data, random_word, output ready);
endinterface

// File: rtl/pci_out_if.sv
// result channel of the processor channel interface
interface pci_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        broadcast;
  logic        dma_valid;
  logic        dma_put;
  logic [31:0] dma_local_addr;
  logic [31:0] dma_eff_high;
  logic [31:0] dma_eff_low;
  logic [31:0] dma_size;
  logic [31:0] dma_tag;
  logic        refused;

  modport source (
    output valid, read_data, broadcast, dma_valid, dma_put, dma_local_addr,
           dma_eff_high, dma_eff_low, dma_size, dma_tag, refused,
    input  ready
  );
  modport sink (
    input  valid, read_data, broadcast, dma_valid, dma_put, dma_local_addr,
           dma_eff_high, dma_eff_low, dma_size, dma_tag, refused,
    output ready
  );
endinterface

// File: rtl/pci_inbox.sv
// inbound mailbox ring with read and write pointers and fill count
module pci_inbox #(
  parameter int unsigned INBOX_DEPTH = pci_pkg::InboxDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  logic                               pop_i,
  input  logic [31:0]                        wdata_i,
  output logic [31:0]                        rdata_o,
  output logic [$clog2(INBOX_DEPTH+1)-1:0]   used_o,
  output logic                               full_o,
  output logic                               empty_o
);

  localparam int unsigned PtrW = $clog2(INBOX_DEPTH);
  localparam int unsigned CntW = $clog2(INBOX_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(INBOX_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(INBOX_DEPTH);

  logic [31:0]     ring_q [INBOX_DEPTH];
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] used_q, used_d;

  // pointer wrap and fill count
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    used_d   = used_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      used_d   = used_q + 1'b1;
    end else if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      used_d   = used_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      used_q   <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      used_q   <= used_d;
    end
  end

  // ring storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ring_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = ring_q[rd_ptr_q];
  assign used_o  = used_q;
  assign full_o  = (used_q == FullCnt);
  assign empty_o = (used_q == '0);

endmodule

// File: rtl/pci_core.sv
// access decode, dma parameter registers, tag state and one-entry mailboxes
module pci_core #(
  parameter int unsigned INBOX_DEPTH = pci_pkg::InboxDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  pci_pkg::pci_item_t               item_i,
  input  logic [31:0]                      inbox_rdata_i,
  input  logic [$clog2(INBOX_DEPTH+1)-1:0] inbox_used_i,
  input  logic                             inbox_full_i,
  input  logic                             inbox_empty_i,
  output logic                             inbox_push_o,
  output logic                             inbox_pop_o,
  output pci_pkg::pci_result_t             result_o
);

  localparam int unsigned CntW = $clog2(INBOX_DEPTH + 1);

  logic [31:0] local_addr_q, eff_high_q, eff_low_q, size_q, tag_q;
  logic [31:0] tag_mask_q, tag_status_q, out_mbox_q, intr_mbox_q;
  logic        out_free_q, intr_free_q;

  logic        wr_en, rd_en;
  logic        ld_out, ld_intr, clr_out, clr_intr;

  assign wr_en  = fire_i && (item_i.action == pci_pkg::ActChWrite);
  assign rd_en  = fire_i && (item_i.action == pci_pkg::ActChRead);

  // mailbox handshakes
  assign ld_out   = wr_en && (item_i.channel == pci_pkg::ChOutMbox) && out_free_q;
  assign ld_intr  = wr_en && (item_i.channel == pci_pkg::ChIntrMbox) && intr_free_q;
  assign clr_out  = fire_i && (item_i.action == pci_pkg::ActHostOutRead) && !out_free_q;
  assign clr_intr = fire_i && (item_i.action == pci_pkg::ActHostIntrRead) && !intr_free_q;

  assign inbox_push_o = fire_i && (item_i.action == pci_pkg::ActHostInWrite) && !inbox_full_i;
  assign inbox_pop_o  = rd_en && (item_i.channel == pci_pkg::ChInMbox) && !inbox_empty_i;

  // channel register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
      eff_high_q   <= '0;
      eff_low_q    <= '0;
      size_q       <= '0;
      tag_q        <= '0;
      tag_mask_q   <= '0;
      tag_status_q <= '0;
      out_mbox_q   <= '0;
      intr_mbox_q  <= '0;
      out_free_q   <= 1'b1;
      intr_free_q  <= 1'b1;
    end else begin
      if (wr_en) begin
        case (item_i.channel)
          pci_pkg::ChLocalAddr: local_addr_q <= item_i.write_data;
          pci_pkg::ChEffHigh:   eff_high_q   <= item_i.write_data;
          pci_pkg::ChEffLow:    eff_low_q    <= item_i.write_data;
          pci_pkg::ChSize:      size_q       <= item_i.write_data;
          pci_pkg::ChTag:       tag_q        <= item_i.write_data;
          pci_pkg::ChTagMask:   tag_mask_q   <= item_i.write_data;
          pci_pkg::ChTagUpdate: tag_status_q <= tag_mask_q;
          default: ;
        endcase
      end
      if (ld_out) begin
        out_mbox_q <= item_i.write_data;
        out_free_q <= 1'b0;
      end else if (clr_out) begin
        out_free_q <= 1'b1;
      end
      if (ld_intr) begin
        intr_mbox_q <= item_i.write_data;
        intr_free_q <= 1'b0;
      end else if (clr_intr) begin
        intr_free_q <= 1'b1;
      end
    end
  end

  // result word
  always_comb begin
    result_o = '0;
    case (item_i.action)
      pci_pkg::ActChWrite: begin
        if (item_i.channel == pci_pkg::ChCommand &&
            (item_i.write_data == pci_pkg::CmdGet || item_i.write_data == pci_pkg::CmdPut)) begin
          result_o.dma_valid      = 1'b1;
          result_o.dma_put        = (item_i.write_data == pci_pkg::CmdPut);
          result_o.dma_local_addr = local_addr_q;
          result_o.dma_eff_high   = eff_high_q;
          result_o.dma_eff_low    = eff_low_q;
          result_o.dma_size       = size_q;
          result_o.dma_tag        = tag_q;
        end
      end
      pci_pkg::ActChRead: begin
        case (item_i.channel)
          pci_pkg::ChTagStatus: result_o.read_data = tag_status_q;
          pci_pkg::ChInMbox: begin
            if (!inbox_empty_i) begin
              result_o.read_data = inbox_rdata_i;
              result_o.broadcast = 1'b1;
            end
          end
          pci_pkg::ChRandom: result_o.read_data = item_i.random_word;
          default: ;
        endcase
      end
      pci_pkg::ActChCount: begin
        case (item_i.channel)
          pci_pkg::ChTagUpdate,
          pci_pkg::ChTagStatus,
          pci_pkg::ChEventAck,
          pci_pkg::ChRandom:   result_o.read_data = 32'd1;
          pci_pkg::ChOutMbox:  result_o.read_data = {31'd0, out_free_q};
          pci_pkg::ChIntrMbox: result_o.read_data = {31'd0, intr_free_q};
          pci_pkg::ChInMbox:   result_o.read_data = {{(32-CntW){1'b0}}, inbox_used_i};
          default: ;
        endcase
      end
      pci_pkg::ActHostInWrite:  result_o.refused   = inbox_full_i;
      pci_pkg::ActHostOutRead:  result_o.read_data = out_free_q ? 32'd0 : out_mbox_q;
      pci_pkg::ActHostIntrRead: result_o.read_data = intr_free_q ? 32'd0 : intr_mbox_q;
      default: ;
    endcase
  end

endmodule

// File: rtl/processor_channel_interface_top.sv
// top level of the processor channel interface: input stage, core, inbox, result stage
// an accepted word goes to the input register, its result to the result register
// throughput: one word per cycle; the input stage advances whenever the result stage
//   is empty or its word is taken in the same cycle
// reset (rst_ni low, asynchronous): both stages empty, dma registers, tag state and
//   mailboxes cleared, mailboxes marked empty; inbound ring contents are not cleared
module processor_channel_interface_top #(
  parameter int unsigned INBOX_DEPTH = pci_pkg::InboxDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pci_in_if.sink    in_i,
  pci_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(INBOX_DEPTH + 1);

  logic                 in_vld_q;
  pci_pkg::pci_item_t   item_q;
  logic                 out_vld_q;
  pci_pkg::pci_result_t res_q;
  pci_pkg::pci_result_t res_d;
  logic                 advance;
  logic                 fire;

  logic                 push, pop, full, empty;
  logic [31:0]          head;
  logic [CntW-1:0]      used;

  // stage control
  assign advance    = !out_vld_q || out_o.ready;
  assign fire       = in_vld_q && advance;
  assign in_i.ready = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.action      <= in_i.action;
      item_q.channel     <= in_i.channel;
      item_q.write_data  <= in_i.write_data;
      item_q.random_word <= in_i.random_word;
    end
  end

  pci_core #(
    .INBOX_DEPTH(INBOX_DEPTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (item_q),
    .inbox_rdata_i (head),
    .inbox_used_i  (used),
    .inbox_full_i  (full),
    .inbox_empty_i (empty),
    .inbox_push_o  (push),
    .inbox_pop_o   (pop),
    .result_o      (res_d)
  );

  pci_inbox #(
    .INBOX_DEPTH(INBOX_DEPTH)
  ) u_inbox (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .wdata_i (item_q.write_data),
    .rdata_o (head),
    .used_o  (used),
    .full_o  (full),
    .empty_o (empty)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.read_data      = res_q.read_data;
  assign out_o.broadcast      = res_q.broadcast;
  assign out_o.dma_valid      = res_q.dma_valid;
  assign out_o.dma_put        = res_q.dma_put;
  assign out_o.dma_local_addr = res_q.dma_local_addr;
  assign out_o.dma_eff_high   = res_q.dma_eff_high;
  assign out_o.dma_eff_low    = res_q.dma_eff_low;
  assign out_o.dma_size       = res_q.dma_size;
  assign out_o.dma_tag        = res_q.dma_tag;
  assign out_o.refused        = res_q.refused;

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench of the processor channel interface with its own access predictor
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  // spare actions the block ignores, bogus command, unknown channels, random word count
  localparam logic [2:0] ActSpareLo = 3'd6;
  localparam logic [2:0] ActSpareHi = 3'd7;
  localparam logic [31:0] CmdBogus = 32'h0000_0060;
  localparam logic [6:0] ChUnknownLo = 7'd0;
  localparam logic [6:0] ChUnknownHi = 7'd127;
  localparam int unsigned RandomWords = 1295;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pci_in_if  in_if ();
  pci_out_if out_if ();

  processor_channel_interface_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor state: dma parameters, tag state and mailboxes
  logic [31:0] dma_laddr, dma_eah, dma_eal, dma_sz, dma_tg;
  logic [31:0] mask_q, status_q;
  logic [31:0] outbox_word, intrbox_word;
  logic        outbox_empty, intrbox_empty;
  logic [31:0] inbox_mem [pci_pkg::InboxDepth];
  int unsigned inbox_rd, inbox_wr, inbox_free;

  pci_pkg::pci_result_t expected_results [$];
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  bit          idle_on = 1'b1;
  int unsigned hold_len = 0;

  // clock
  always #6 clk_i = ~clk_i;

  // predicted result of one access, updating the predictor state
  function automatic pci_pkg::pci_result_t predict_access(pci_pkg::pci_item_t it);
    pci_pkg::pci_result_t r;
    r = '0;
    case (it.action)
      pci_pkg::ActChWrite: begin
        case (it.channel)
          pci_pkg::ChLocalAddr: dma_laddr = it.write_data;
          pci_pkg::ChEffHigh:   dma_eah = it.write_data;
          pci_pkg::ChEffLow:    dma_eal = it.write_data;
          pci_pkg::ChSize:      dma_sz = it.write_data;
          pci_pkg::ChTag:       dma_tg = it.write_data;
          pci_pkg::ChCommand: begin
            if (it.write_data == pci_pkg::CmdGet || it.write_data == pci_pkg::CmdPut) begin
              r.dma_valid      = 1'b1;
              r.dma_put        = (it.write_data == pci_pkg::CmdPut);
              r.dma_local_addr = dma_laddr;
              r.dma_eff_high   = dma_eah;
              r.dma_eff_low    = dma_eal;
              r.dma_size       = dma_sz;
              r.dma_tag        = dma_tg;
            end
          end
          pci_pkg::ChTagMask:   mask_q = it.write_data;
          pci_pkg::ChTagUpdate: status_q = mask_q;
          pci_pkg::ChOutMbox: begin
            if (outbox_empty) begin
              outbox_word  = it.write_data;
              outbox_empty = 1'b0;
            end
          end
          pci_pkg::ChIntrMbox: begin
            if (intrbox_empty) begin
              intrbox_word  = it.write_data;
              intrbox_empty = 1'b0;
            end
          end
          default: ;
        endcase
      end
      pci_pkg::ActChRead: begin
        if (it.channel == pci_pkg::ChTagStatus) begin
          r.read_data = status_q;
        end else if (it.channel == pci_pkg::ChInMbox) begin
          if (inbox_free < pci_pkg::InboxDepth) begin
            r.read_data = inbox_mem[inbox_rd];
            r.broadcast = 1'b1;
            inbox_rd    = (inbox_rd + 1) % pci_pkg::InboxDepth;
            inbox_free++;
          end
        end else if (it.channel == pci_pkg::ChRandom) begin
          r.read_data = it.random_word;
        end
      end
      pci_pkg::ActChCount: begin
        case (it.channel)
          pci_pkg::ChTagUpdate, pci_pkg::ChTagStatus, pci_pkg::ChEventAck,
          pci_pkg::ChRandom:   r.read_data = 32'd1;
          pci_pkg::ChOutMbox:  r.read_data = {31'd0, outbox_empty};
          pci_pkg::ChIntrMbox: r.read_data = {31'd0, intrbox_empty};
          pci_pkg::ChInMbox:   r.read_data = pci_pkg::InboxDepth - inbox_free;
          default: ;
        endcase
      end
      pci_pkg::ActHostInWrite: begin
        if (inbox_free == 0) begin
          r.refused = 1'b1;
        end else begin
          inbox_mem[inbox_wr] = it.write_data;
          inbox_wr = (inbox_wr + 1) % pci_pkg::InboxDepth;
          inbox_free--;
        end
      end
      pci_pkg::ActHostOutRead: begin
        if (!outbox_empty) begin
          r.read_data  = outbox_word;
          outbox_empty = 1'b1;
        end
      end
      pci_pkg::ActHostIntrRead: begin
        if (!intrbox_empty) begin
          r.read_data   = intrbox_word;
          intrbox_empty = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // word with extra weight on the extremes
  function automatic logic [31:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return 32'h0000_0000;
    if (sel < 16) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // send one access, with an occasional gap before it
  task automatic send_access(logic [2:0] act, logic [6:0] ch, logic [31:0] wd,
                             logic [31:0] rnd);
    pci_pkg::pci_item_t it;
    it = '{action: act, channel: ch, write_data: wd, random_word: rnd};
    if (idle_on && $urandom_range(0, 99) < 10) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= it.action;
    in_if.channel     <= it.channel;
    in_if.write_data  <= it.write_data;
    in_if.random_word <= it.random_word;
    do @(posedge clk_i); while (!in_if.ready);
    expected_results.push_back(predict_access(it));
    words_sent++;
  endtask

  // one random access, mostly on channels the block knows
  task automatic send_random_access();
    logic [6:0] ch;
    int unsigned sel;
    logic [6:0] wr_set [10] = '{pci_pkg::ChLocalAddr, pci_pkg::ChEffHigh, pci_pkg::ChEffLow,
                               pci_pkg::ChSize, pci_pkg::ChTag, pci_pkg::ChCommand,
                               pci_pkg::ChTagMask, pci_pkg::ChTagUpdate, pci_pkg::ChOutMbox,
                               pci_pkg::ChIntrMbox};
    logic [6:0] rd_set [4] = '{pci_pkg::ChTagStatus, pci_pkg::ChInMbox, pci_pkg::ChInMbox,
                              pci_pkg::ChRandom};
    logic [6:0] cnt_set [7] = '{pci_pkg::ChTagUpdate, pci_pkg::ChTagStatus,
                               pci_pkg::ChEventAck, pci_pkg::ChOutMbox, pci_pkg::ChInMbox,
                               pci_pkg::ChIntrMbox, pci_pkg::ChRandom};
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      ch = ($urandom_range(0, 9) == 0) ? 7'($urandom) : wr_set[$urandom_range(0, 9)];
      if (ch == pci_pkg::ChCommand && $urandom_range(0, 1))
        send_access(pci_pkg::ActChWrite, ch,
                    $urandom_range(0, 1) ? pci_pkg::CmdGet : pci_pkg::CmdPut, $urandom);
      else
        send_access(pci_pkg::ActChWrite, ch, pick_word(), $urandom);
    end else if (sel < 52) begin
      ch = ($urandom_range(0, 9) == 0) ? 7'($urandom) : rd_set[$urandom_range(0, 3)];
      send_access(pci_pkg::ActChRead, ch, $urandom, pick_word());
    end else if (sel < 64) begin
      ch = ($urandom_range(0, 9) == 0) ? 7'($urandom) : cnt_set[$urandom_range(0, 6)];
      send_access(pci_pkg::ActChCount, ch, $urandom, $urandom);
    end else if (sel < 78) begin
      send_access(pci_pkg::ActHostInWrite, 7'($urandom), pick_word(), $urandom);
    end else if (sel < 88) begin
      send_access(pci_pkg::ActHostOutRead, 7'($urandom), $urandom, $urandom);
    end else if (sel < 96) begin
      send_access(pci_pkg::ActHostIntrRead, 7'($urandom), $urandom, $urandom);
    end else begin
      send_access($urandom_range(0, 1) ? ActSpareLo : ActSpareHi, 7'($urandom),
                  $urandom, $urandom);
    end
  endtask

  // full dma setup: parameters, command, then tag wait
  task automatic send_dma_sequence();
    send_access(pci_pkg::ActChWrite, pci_pkg::ChLocalAddr, pick_word(), $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChEffHigh, pick_word(), $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChEffLow, pick_word(), $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChSize, pick_word(), $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChTag, pick_word(), $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChCommand,
                $urandom_range(0, 1) ? pci_pkg::CmdGet : pci_pkg::CmdPut, $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChTagMask, pick_word(), $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChTagUpdate, $urandom, $urandom);
    send_access(pci_pkg::ActChRead, pci_pkg::ChTagStatus, $urandom, $urandom);
  endtask

  // counts and reads right after reset
  task automatic test_reset_state();
    send_access(pci_pkg::ActChCount, pci_pkg::ChOutMbox, $urandom, $urandom);
    send_access(pci_pkg::ActChCount, pci_pkg::ChInMbox, $urandom, $urandom);
    send_access(pci_pkg::ActChRead, pci_pkg::ChInMbox, $urandom, $urandom);
    send_access(pci_pkg::ActHostOutRead, ChUnknownLo, $urandom, $urandom);
  endtask

  // dma parameters at their extremes and every command word kind
  task automatic test_dma_params();
    send_access(pci_pkg::ActChWrite, pci_pkg::ChLocalAddr, 32'hFFFF_FFFF, $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChEffHigh, 32'h0000_0000, $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChEffLow, 32'hFFFF_FFFF, $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChSize, 32'h0000_0000, $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChTag, 32'hFFFF_FFFF, $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChCommand, pci_pkg::CmdGet, $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChCommand, pci_pkg::CmdPut, $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChCommand, CmdBogus, $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChTagMask, 32'hFFFF_FFFF, $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChTagUpdate, $urandom, $urandom);
    send_access(pci_pkg::ActChRead, pci_pkg::ChTagStatus, $urandom, $urandom);
  endtask

  // full outbound box, interrupt box, and inbound ring overflow
  task automatic test_mailboxes();
    send_access(pci_pkg::ActChWrite, pci_pkg::ChOutMbox, 32'hA5A5_0001, $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChOutMbox, 32'h5A5A_0002, $urandom);
    send_access(pci_pkg::ActHostOutRead, ChUnknownHi, $urandom, $urandom);
    send_access(pci_pkg::ActChWrite, pci_pkg::ChIntrMbox, 32'hFFFF_FFFF, $urandom);
    send_access(pci_pkg::ActHostIntrRead, ChUnknownLo, $urandom, $urandom);
    repeat (pci_pkg::InboxDepth + 1)
      send_access(pci_pkg::ActHostInWrite, 7'($urandom), $urandom, $urandom);
    send_access(pci_pkg::ActChCount, pci_pkg::ChInMbox, $urandom, $urandom);
    send_access(pci_pkg::ActChRead, pci_pkg::ChInMbox, $urandom, $urandom);
  endtask

  // spare action codes, random channel and unknown channel
  task automatic test_spare_and_random();
    send_access(ActSpareLo, pci_pkg::ChTagStatus, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(ActSpareHi, ChUnknownHi, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(pci_pkg::ActChRead, pci_pkg::ChRandom, $urandom, 32'hFFFF_FFFF);
    send_access(pci_pkg::ActChWrite, ChUnknownHi, 32'hFFFF_FFFF, $urandom);
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_holdoff();
    hold_len = 150;
    repeat (24) send_random_access();
  endtask

  // random traffic, the first stretch with no idling on either side
  task automatic test_random_traffic();
    int unsigned target;
    target = words_sent + RandomWords;
    idle_on = 1'b0;
    while (words_sent < target) begin
      if (idle_on == 1'b0 && words_sent + RandomWords > target + 300) idle_on = 1'b1;
      if ($urandom_range(0, 99) < 30) send_dma_sequence();
      else send_random_access();
    end
  endtask

  // result side ready, with random stalls and requested hold-offs
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        hold_left = hold_len;
        hold_len = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(0, 99) < 10);
      end
    end
  end

  // compare each accepted result with the oldest prediction
  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    pci_pkg::pci_result_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result word: expected none actual %h", $time,
                 out_if.read_data);
      end else begin
        exp_r = expected_results.pop_front();
        check_field("read_data", exp_r.read_data, out_if.read_data);
        check_field("broadcast", {31'd0, exp_r.broadcast}, {31'd0, out_if.broadcast});
        check_field("dma_valid", {31'd0, exp_r.dma_valid}, {31'd0, out_if.dma_valid});
        check_field("dma_put", {31'd0, exp_r.dma_put}, {31'd0, out_if.dma_put});
        check_field("dma_local_addr", exp_r.dma_local_addr, out_if.dma_local_addr);
        check_field("dma_eff_high", exp_r.dma_eff_high, out_if.dma_eff_high);
        check_field("dma_eff_low", exp_r.dma_eff_low, out_if.dma_eff_low);
        check_field("dma_size", exp_r.dma_size, out_if.dma_size);
        check_field("dma_tag", exp_r.dma_tag, out_if.dma_tag);
        check_field("refused", {31'd0, exp_r.refused}, {31'd0, out_if.refused});
      end
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // reset, directed tests, random traffic, drain
  initial begin
    in_if.valid = 1'b0;
    in_if.action = pci_pkg::ActChWrite;
    in_if.channel = '0;
    in_if.write_data = '0;
    in_if.random_word = '0;
    dma_laddr = '0;
    dma_eah = '0;
    dma_eal = '0;
    dma_sz = '0;
    dma_tg = '0;
    mask_q = '0;
    status_q = '0;
    outbox_word = '0;
    intrbox_word = '0;
    outbox_empty = 1'b1;
    intrbox_empty = 1'b1;
    inbox_rd = 0;
    inbox_wr = 0;
    inbox_free = pci_pkg::InboxDepth;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_dma_params();
    test_mailboxes();
    test_spare_and_random();
    test_holdoff();
    test_random_traffic();
    in_if.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
